// ===== hdl/voxel_shell_site_finder_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel shell site finder assertion macros
// Concurrent check macros for the site finder; empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef VOXEL_SHELL_SITE_FINDER_DEFINES_SVH
`define VOXEL_SHELL_SITE_FINDER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define VSSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define VSSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VSSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define VSSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/vssf_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel shell site finder package
// Constants, codes and item types shared by the site finder modules.
// ----------------------------------------------------------------------------
package vssf_pkg;

	localparam int GRID_DIM   = 32;
	localparam int COORD_W    = 5;
	localparam int ADDR_W     = 3 * COORD_W;
	localparam int VOXELS     = 1 << ADDR_W;
	localparam int REACH_W    = 5;
	localparam int SIZE_W     = 6;
	localparam int DIR_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int SLOT_W     = 3;
	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_AW    = 1;
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_AW    = 2;

	localparam logic [REACH_W-1:0] REACH_RESET = 5'd1;
	localparam logic [SIZE_W-1:0]  SIZE_RESET  = 6'd32;

	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [0:0] {
		CMD_LOAD  = 1'b0,
		CMD_PROBE = 1'b1
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REACH  = 2'd0,
		CFG_SIZE_X = 2'd1,
		CFG_SIZE_Y = 2'd2,
		CFG_SIZE_Z = 2'd3
	} cfg_reg_e;

	typedef enum logic [DIR_W-1:0] {
		DIR_XN = 3'd0,
		DIR_XP = 3'd1,
		DIR_YP = 3'd2,
		DIR_YN = 3'd3,
		DIR_ZN = 3'd4,
		DIR_ZP = 3'd5
	} dir_e;

	// Memory read slots of one probe: the centre, then one per direction.
	typedef enum logic [SLOT_W-1:0] {
		SLOT_CENTRE = 3'd0,
		SLOT_XN     = 3'd1,
		SLOT_XP     = 3'd2,
		SLOT_YP     = 3'd3,
		SLOT_YN     = 3'd4,
		SLOT_ZN     = 3'd5,
		SLOT_ZP     = 3'd6
	} slot_e;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} back_state_e;

	typedef struct packed {
		logic   cmd;
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		logic   occupied;
	} item_t;

	typedef struct packed {
		logic             found;
		coord_t           site_x;
		coord_t           site_y;
		coord_t           site_z;
		logic [DIR_W-1:0] direction;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [REACH_W-1:0] reach;
		logic [SIZE_W-1:0]  size_x;
		logic [SIZE_W-1:0]  size_y;
		logic [SIZE_W-1:0]  size_z;
	} cfg_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vox_t;

	typedef struct packed {
		logic   cmd;
		logic   occupied;
		vox_t   centre;
		coord_t xn;
		coord_t xp;
		coord_t yp;
		coord_t yn;
		coord_t zn;
		coord_t zp;
	} job_t;

endpackage

// ===== hdl/vssf_front.sv =====
// ----------------------------------------------------------------------------
// Site finder front end
// Accepts items, works out the clamped neighbour coordinates and queues jobs.
// ----------------------------------------------------------------------------
module vssf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  vssf_pkg::cfg_t cfg,
	input  logic           clearing,
	input  logic           push,
	output logic           full,
	input  vssf_pkg::item_t item,
	output logic           job_valid,
	input  logic           job_take,
	output vssf_pkg::job_t job
);
	import vssf_pkg::*;

	job_t                 jobq_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0]   wr_ptr_q;
	logic [JOBQ_AW-1:0]   rd_ptr_q;
	logic [JOBQ_AW:0]     cnt_q;
	logic                 accept;
	job_t                 new_job;
	coord_t               top_x;
	coord_t               top_y;
	coord_t               top_z;

	function automatic coord_t top_of(logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] s;
		s = size;
		if (s == '0) begin
			s = SIZE_W'(1);
		end
		if (s > SIZE_W'(GRID_DIM)) begin
			s = SIZE_W'(GRID_DIM);
		end
		return COORD_W'(s - SIZE_W'(1));
	endfunction

	function automatic coord_t step_down(coord_t c, logic [REACH_W-1:0] r);
		logic [COORD_W:0] rr;
		rr = (COORD_W + 1)'(r);
		return ({1'b0, c} > rr) ? COORD_W'({1'b0, c} - rr) : '0;
	endfunction

	function automatic coord_t step_up(coord_t c, logic [REACH_W-1:0] r, coord_t top);
		logic [COORD_W:0] sum;
		sum = {1'b0, c} + (COORD_W + 1)'(r);
		return (sum < {1'b0, top}) ? sum[COORD_W-1:0] : top;
	endfunction

	assign full      = clearing || (cnt_q == (JOBQ_AW + 1)'(JOBQ_DEPTH));
	assign accept    = push && !full;
	assign job_valid = (cnt_q != '0);
	assign job       = jobq_q[rd_ptr_q];

	assign top_x = top_of(cfg.size_x);
	assign top_y = top_of(cfg.size_y);
	assign top_z = top_of(cfg.size_z);

	always_comb begin
		new_job.cmd      = item.cmd;
		new_job.occupied = item.occupied;
		new_job.centre.x = item.pos_x;
		new_job.centre.y = item.pos_y;
		new_job.centre.z = item.pos_z;
		new_job.xn       = step_down(item.pos_x, cfg.reach);
		new_job.xp       = step_up(item.pos_x, cfg.reach, top_x);
		new_job.yp       = step_up(item.pos_y, cfg.reach, top_y);
		new_job.yn       = step_down(item.pos_y, cfg.reach);
		new_job.zn       = step_down(item.pos_z, cfg.reach);
		new_job.zp       = step_up(item.pos_z, cfg.reach, top_z);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			jobq_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + JOBQ_AW'(1);
			end
			if (job_take) begin
				rd_ptr_q <= rd_ptr_q + JOBQ_AW'(1);
			end
			if (accept && !job_take) begin
				cnt_q <= cnt_q + (JOBQ_AW + 1)'(1);
			end else if (!accept && job_take) begin
				cnt_q <= cnt_q - (JOBQ_AW + 1)'(1);
			end
		end
	end

endmodule

// ===== hdl/vssf_back.sv =====
// ----------------------------------------------------------------------------
// Site finder back end
// Owns the occupancy memory and walks each job through its memory accesses.
// ----------------------------------------------------------------------------
module vssf_back (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          clearing,
	input  logic                          job_valid,
	input  vssf_pkg::job_t                job,
	output logic                          job_take,
	input  logic [vssf_pkg::RESQ_AW:0]    res_free,
	output logic                          res_push,
	output vssf_pkg::result_t             res_data
);
	import vssf_pkg::*;

	logic                occ_mem [VOXELS];
	back_state_e         state_q;
	back_state_e         state_d;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   slot_d;
	logic                rd_v_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic                rd_data_s1;
	job_t                job_q;
	logic                hold_v_q;
	logic                hold_v_d;
	result_t             hold_q;
	result_t             hold_d;
	logic                mem_we;
	logic                mem_re;
	logic                mem_wd;
	logic [ADDR_W-1:0]   mem_addr;
	vox_t                rd_vox;
	vox_t                ret_vox;

	function automatic vox_t pick_vox(job_t j, logic [SLOT_W-1:0] slot);
		vox_t v;
		v = j.centre;
		case (slot)
			SLOT_XN: v.x = j.xn;
			SLOT_XP: v.x = j.xp;
			SLOT_YP: v.y = j.yp;
			SLOT_YN: v.y = j.yn;
			SLOT_ZN: v.z = j.zn;
			SLOT_ZP: v.z = j.zp;
			default: v = j.centre;
		endcase
		return v;
	endfunction

	assign clearing = (state_q == ST_CLEAR);
	assign rd_vox   = pick_vox(job_q, slot_q);
	assign ret_vox  = pick_vox(job_q, slot_s1);

	always_comb begin
		state_d  = state_q;
		slot_d   = slot_q;
		hold_v_d = hold_v_q;
		hold_d   = hold_q;
		job_take = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_wd   = 1'b0;
		mem_addr = rd_vox;
		res_push = 1'b0;
		res_data = hold_q;
		unique case (state_q) inside
			ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_addr_q;
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					if (job.cmd == CMD_LOAD) begin
						mem_we   = 1'b1;
						mem_wd   = job.occupied;
						mem_addr = job.centre;
					end else begin
						state_d  = ST_READ;
						slot_d   = SLOT_CENTRE;
						hold_v_d = 1'b0;
					end
				end
			end
			ST_READ, ST_DRAIN: begin
				if (state_q == ST_READ && res_free >= (RESQ_AW + 1)'(2)) begin
					mem_re = 1'b1;
					slot_d = slot_q + SLOT_W'(1);
					if (slot_q == SLOT_ZP) begin
						state_d = ST_DRAIN;
					end
				end
				if (state_q == ST_DRAIN) begin
					state_d = ST_DONE;
				end
				if (rd_v_s1) begin
					if (slot_s1 == SLOT_CENTRE) begin
						if (!rd_data_s1) begin
							state_d = ST_DONE;
						end
					end else if (!rd_data_s1) begin
						res_push         = hold_v_q;
						res_data.last    = 1'b0;
						hold_v_d         = 1'b1;
						hold_d.found     = 1'b1;
						hold_d.site_x    = ret_vox.x;
						hold_d.site_y    = ret_vox.y;
						hold_d.site_z    = ret_vox.z;
						hold_d.direction = DIR_W'(slot_s1 - SLOT_W'(1));
						hold_d.last      = 1'b0;
					end
				end
			end
			ST_DONE: begin
				if (res_free != '0) begin
					res_push = 1'b1;
					if (hold_v_q) begin
						res_data      = hold_q;
						res_data.last = 1'b1;
					end else begin
						res_data      = '0;
						res_data.last = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			occ_mem[mem_addr] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= occ_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job;
		end
		if (mem_re) begin
			slot_s1 <= slot_q;
		end
		hold_q <= hold_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			slot_q     <= SLOT_CENTRE;
			rd_v_s1    <= 1'b0;
			hold_v_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			slot_q   <= slot_d;
			rd_v_s1  <= mem_re;
			hold_v_q <= hold_v_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

endmodule

// ===== hdl/vssf_res_q.sv =====
// ----------------------------------------------------------------------------
// Site finder result queue
// Small queue that holds result items until the receiver takes them.
// ----------------------------------------------------------------------------
module vssf_res_q (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  vssf_pkg::result_t          wr_data,
	output logic [vssf_pkg::RESQ_AW:0] free_slots,
	input  logic                       rd_en,
	output logic                       empty,
	output vssf_pkg::result_t          rd_data
);
	import vssf_pkg::*;

	result_t              entry_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0]   wr_ptr_q;
	logic [RESQ_AW-1:0]   rd_ptr_q;
	logic [RESQ_AW:0]     cnt_q;
	logic                 do_rd;

	assign empty      = (cnt_q == '0);
	assign do_rd      = rd_en && !empty;
	assign rd_data    = entry_q[rd_ptr_q];
	assign free_slots = (RESQ_AW + 1)'(RESQ_DEPTH) - cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + RESQ_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + RESQ_AW'(1);
			end
			if (wr_en && !do_rd) begin
				cnt_q <= cnt_q + (RESQ_AW + 1)'(1);
			end else if (!wr_en && do_rd) begin
				cnt_q <= cnt_q - (RESQ_AW + 1)'(1);
			end
		end
	end

endmodule

// ===== hdl/voxel_shell_site_finder.sv =====
// ----------------------------------------------------------------------------
// Voxel shell site finder
// Occupancy map with a probe that reports empty voxels around an occupied one.
// ----------------------------------------------------------------------------
// Items enter through push/full and carry a load or a probe. Results leave
// through empty/pop; the oldest result sits on the result port while empty
// is low. A load produces no result, a probe produces one to six results,
// the final one flagged with last. Registers are written through cfg_wen,
// cfg_index and cfg_wdata; the user must write them only while the block is
// idle, as the block itself does not enforce it. After reset the occupancy
// memory is cleared one voxel per cycle, all 32768 voxels of it; full stays
// high meanwhile. The back end sets the pace: a load is written as soon as
// its job is taken; a probe takes its job, makes seven single-port memory
// reads (the centre, then one neighbour per direction), waits in the drain
// state for the last read to return and pushes the final result in the done
// state. A probe of an empty voxel stops reading and goes to the done state
// once its centre read returns. A two-entry job queue in front of the
// memory and a four-entry result queue behind it let either side stall;
// when the receiver stops popping, the back end pauses its reads and full
// rises once the job queue fills.
// ----------------------------------------------------------------------------
module voxel_shell_site_finder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [vssf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vssf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              push,
	output logic                              full,
	input  vssf_pkg::item_t                   item,
	output logic                              empty,
	input  logic                              pop,
	output vssf_pkg::result_t                 result
);
	import vssf_pkg::*;
	`include "voxel_shell_site_finder_defines.svh"

	cfg_t                 cfg_q;
	logic                 clearing;
	logic                 job_valid;
	logic                 job_take;
	job_t                 job;
	logic [RESQ_AW:0]     res_free;
	logic                 res_push;
	result_t              res_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reach  <= REACH_RESET;
			cfg_q.size_x <= SIZE_RESET;
			cfg_q.size_y <= SIZE_RESET;
			cfg_q.size_z <= SIZE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_REACH:  cfg_q.reach  <= cfg_wdata[REACH_W-1:0];
				CFG_SIZE_X: cfg_q.size_x <= cfg_wdata[SIZE_W-1:0];
				CFG_SIZE_Y: cfg_q.size_y <= cfg_wdata[SIZE_W-1:0];
				CFG_SIZE_Z: cfg_q.size_z <= cfg_wdata[SIZE_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	vssf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.clearing  (clearing),
		.push      (push),
		.full      (full),
		.item      (item),
		.job_valid (job_valid),
		.job_take  (job_take),
		.job       (job)
	);

	vssf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.res_free  (res_free),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	vssf_res_q u_res_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (res_push),
		.wr_data    (res_data),
		.free_slots (res_free),
		.rd_en      (pop),
		.empty      (empty),
		.rd_data    (result)
	);

	`VSSF_ASSERT_NOW(a_push_has_room, clk, arst_n, res_push, res_free != '0, "result queue overrun")
	`VSSF_ASSERT_NOW(a_take_has_job, clk, arst_n, job_take, job_valid, "job taken from empty queue")
	`VSSF_ASSERT_NOW(a_none_is_last, clk, arst_n, res_push && !res_data.found, res_data.last, "empty answer not last")
	`VSSF_ASSERT_NXT(a_gap_after_last, clk, arst_n, res_push && res_data.last, !res_push, "result follows last item")

endmodule

// ===== verif/voxel_shell_site_finder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voxel shell site finder testbench
// Drives loads and probes into the site finder under random idling on both
// sides, predicts every site from its own copy of the occupancy map and the
// registers, and checks each result field by field in order. The registers
// are changed between phases, covering the zero, maximum and oversize cases.
// ----------------------------------------------------------------------------
module voxel_shell_site_finder_test;
	import vssf_pkg::*;

	localparam int MAX_GAP = 8;
	localparam int SETTLE_CYCLES = 30;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	cfg_reg_e cfg_index = CFG_REACH;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic push = 1'b0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;

	bit occ_map [VOXELS];
	logic [REACH_W-1:0] reach_q = REACH_RESET;
	logic [SIZE_W-1:0] size_x_q = SIZE_RESET;
	logic [SIZE_W-1:0] size_y_q = SIZE_RESET;
	logic [SIZE_W-1:0] size_z_q = SIZE_RESET;

	item_t outgoing_items [$];
	result_t pending_sites [$];
	result_t want_site;
	int error_count = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int coord_span = GRID_DIM;

	voxel_shell_site_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	initial forever #5 clk = ~clk;

	function automatic void note_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic coord_t axis_top(logic [SIZE_W-1:0] extent);
		if (extent == 0)
			return '0;
		if (extent > GRID_DIM)
			return coord_t'(GRID_DIM - 1);
		return coord_t'(extent - 1);
	endfunction

	function automatic coord_t step_down(coord_t c);
		return (c > reach_q) ? coord_t'(c - reach_q) : '0;
	endfunction

	function automatic coord_t step_up(coord_t c, logic [SIZE_W-1:0] extent);
		int sum;
		coord_t top;
		sum = int'(c) + int'(reach_q);
		top = axis_top(extent);
		return (sum < int'(top)) ? coord_t'(sum) : top;
	endfunction

	function automatic vox_t neighbour(vox_t c, dir_e d);
		vox_t n;
		n = c;
		case (d)
		DIR_XN: n.x = step_down(c.x);
		DIR_XP: n.x = step_up(c.x, size_x_q);
		DIR_YP: n.y = step_up(c.y, size_y_q);
		DIR_YN: n.y = step_down(c.y);
		DIR_ZN: n.z = step_down(c.z);
		DIR_ZP: n.z = step_up(c.z, size_z_q);
		default: n = c;
		endcase
		return n;
	endfunction

	// Loads update the map; probes queue their sites, or one empty answer.
	function automatic void predict_sites(item_t it);
		vox_t centre, nb;
		dir_e d;
		result_t r;
		result_t found_sites [$];
		centre = {it.pos_x, it.pos_y, it.pos_z};
		if (it.cmd == CMD_LOAD) begin
			occ_map[centre] = it.occupied;
			return;
		end
		if (occ_map[centre]) begin
			d = DIR_XN;
			repeat (6) begin
				nb = neighbour(centre, d);
				if (!occ_map[nb]) begin
					r = '0;
					r.found = 1'b1;
					r.site_x = nb.x;
					r.site_y = nb.y;
					r.site_z = nb.z;
					r.direction = d;
					found_sites.push_back(r);
				end
				d = d.next();
			end
		end
		if (found_sites.size() == 0) begin
			r = '0;
			r.last = 1'b1;
			found_sites.push_back(r);
		end else begin
			found_sites[found_sites.size() - 1].last = 1'b1;
		end
		pending_sites = {pending_sites, found_sites};
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				predict_sites(item);
			if (!push || !full) begin
				if (tx_wait > 0) begin
					push <= 1'b0;
					tx_wait--;
				end else if (outgoing_items.size() != 0) begin
					item <= outgoing_items.pop_front();
					push <= 1'b1;
					tx_wait = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_sites.size() == 0) begin
					note_error($sformatf("unexpected result %p", result));
				end else begin
					want_site = pending_sites.pop_front();
					if (result.found !== want_site.found || result.site_x !== want_site.site_x ||
							result.site_y !== want_site.site_y ||
							result.site_z !== want_site.site_z ||
							result.direction !== want_site.direction ||
							result.last !== want_site.last)
						note_error($sformatf("result mismatch: expected %p, got %p",
							want_site, result));
				end
				rx_wait = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (rx_wait > 0) begin
				pop <= 1'b0;
				rx_wait--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic void add_item(cmd_e cmd, vox_t v, logic occ);
		item_t it;
		it.cmd = cmd;
		it.pos_x = v.x;
		it.pos_y = v.y;
		it.pos_z = v.z;
		it.occupied = occ;
		outgoing_items.push_back(it);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return coord_t'($urandom_range(0, coord_span - 1));
		endcase
	endfunction

	function automatic vox_t rand_vox();
		return {rand_coord(), rand_coord(), rand_coord()};
	endfunction

	// A filled centre, some of its neighbours loaded, then a probe of it.
	function automatic int add_cluster();
		vox_t centre;
		dir_e d;
		int n;
		n = 2;
		centre = rand_vox();
		add_item(CMD_LOAD, centre, 1'b1);
		d = DIR_XN;
		repeat (6) begin
			if ($urandom_range(0, 1) == 1) begin
				add_item(CMD_LOAD, neighbour(centre, d), 1'($urandom_range(0, 3) != 0));
				n++;
			end
			d = d.next();
		end
		add_item(CMD_PROBE, centre, 1'($urandom_range(0, 1)));
		return n;
	endfunction

	task automatic random_phase(int budget);
		int n;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(0, 3) == 0) begin
				add_item($urandom_range(0, 1) ? CMD_PROBE : CMD_LOAD, rand_vox(),
					1'($urandom_range(0, 1)));
				n++;
			end else begin
				n += add_cluster();
			end
		end
	endtask

	task automatic wait_settled();
		do
			@(negedge clk);
		while (outgoing_items.size() != 0 || push || pending_sites.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
		CFG_REACH: reach_q = value[REACH_W-1:0];
		CFG_SIZE_X: size_x_q = value;
		CFG_SIZE_Y: size_y_q = value;
		CFG_SIZE_Z: size_z_q = value;
		default: ;
		endcase
	endtask

	task automatic set_config(logic [REACH_W-1:0] reach, logic [SIZE_W-1:0] sx,
			logic [SIZE_W-1:0] sy, logic [SIZE_W-1:0] sz);
		write_reg(CFG_REACH, {1'b0, reach});
		write_reg(CFG_SIZE_X, sx);
		write_reg(CFG_SIZE_Y, sy);
		write_reg(CFG_SIZE_Z, sz);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic mix_idling();
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
	endtask

	initial begin
		vox_t corner_lo, corner_hi, mid, enclosed;
		dir_e d;
		corner_lo = '0;
		corner_hi = '1;
		mid = {5'd16, 5'd16, 5'd16};
		enclosed = {5'd5, 5'd5, 5'd5};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: corners, an enclosed voxel, a cleared voxel.
		add_item(CMD_PROBE, corner_lo, 1'b1);
		add_item(CMD_LOAD, corner_hi, 1'b1);
		add_item(CMD_PROBE, corner_hi, 1'b0);
		add_item(CMD_LOAD, corner_lo, 1'b1);
		add_item(CMD_PROBE, corner_lo, 1'b0);
		add_item(CMD_LOAD, enclosed, 1'b1);
		d = DIR_XN;
		repeat (6) begin
			add_item(CMD_LOAD, neighbour(enclosed, d), 1'b1);
			d = d.next();
		end
		add_item(CMD_PROBE, enclosed, 1'b1);
		add_item(CMD_LOAD, enclosed, 1'b0);
		add_item(CMD_PROBE, enclosed, 1'b0);
		add_item(CMD_LOAD, mid, 1'b1);
		add_item(CMD_LOAD, {5'd15, 5'd16, 5'd16}, 1'b1);
		add_item(CMD_PROBE, mid, 1'b1);
		wait_settled();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		random_phase(50);
		wait_settled();

		// Zero reach: every neighbour is the centre itself.
		mix_idling();
		coord_span = 8;
		set_config(5'd0, 6'd32, 6'd32, 6'd32);
		add_item(CMD_PROBE, corner_lo, 1'b0);
		random_phase(40);
		wait_settled();

		// Maximum reach, oversize and zero extents.
		mix_idling();
		coord_span = GRID_DIM;
		set_config(5'd31, 6'd63, 6'd0, 6'd32);
		add_item(CMD_PROBE, corner_hi, 1'b0);
		random_phase(50);
		wait_settled();

		// Small extents, with a centre lying beyond the x extent.
		mix_idling();
		coord_span = 8;
		set_config(5'd2, 6'd4, 6'd5, 6'd6);
		add_item(CMD_LOAD, {5'd20, 5'd3, 5'd3}, 1'b1);
		add_item(CMD_PROBE, {5'd20, 5'd3, 5'd3}, 1'b0);
		random_phase(60);
		wait_settled();

		mix_idling();
		coord_span = 4;
		set_config(5'd1, 6'd1, 6'd1, 6'd1);
		random_phase(40);
		wait_settled();

		repeat (2) begin
			mix_idling();
			coord_span = $urandom_range(0, 1) ? 16 : 8;
			set_config(5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
				6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			random_phase(40);
			wait_settled();
		end

		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
